// ===== rtl/core/cmdopt_pkg.sv =====
// shared constants, types and helpers for the command-line option finder
`timescale 1ns / 1ps

package cmdopt_pkg;

	localparam int unsigned NAME_BYTES   = 8;
	localparam int unsigned LENGTH_LIMIT = 4095;
	localparam int unsigned BUF_MAX      = 4096;

	localparam int unsigned POS_W  = $clog2(NAME_BYTES + 1);
	localparam int unsigned SEL_W  = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
	localparam int unsigned CNT_W  = 12;
	localparam int unsigned BSZ_W  = 13;
	localparam int unsigned NAME_W = 64;
	localparam int unsigned LEN_W  = 4;

	localparam int unsigned DATA_W = 64;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 24;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_EQ  = 8'h3d;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_HT  = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_VT  = 8'h0b;
	localparam logic [7:0] CH_FF  = 8'h0c;
	localparam logic [7:0] CH_CR  = 8'h0d;

	typedef enum logic [1:0] {
		REG_NAME   = 2'd0,
		REG_LENGTH = 2'd1,
		REG_FLAG   = 2'd2,
		REG_BUFSZ  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_SKIP  = 3'd0,
		PH_CMP   = 3'd1,
		PH_WORD  = 3'd2,
		PH_VALUE = 3'd3,
		PH_DONE  = 3'd4
	} phase_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_HT) || (c == CH_LF) ||
			(c == CH_VT) || (c == CH_FF) || (c == CH_CR);
	endfunction

endpackage

// ===== rtl/core/command_line_option_finder_top.sv =====
// command-line option finder: stream in characters, stream out value bytes and a final answer
//
// usage: characters of a command line enter on the s_ side, one item per character, a zero
// character ends the string. in value mode every value character of the first name=value word
// leaves on the m_ side with m_tuser low (subject to buffer_size); the zero character then
// produces one item with m_tuser high carrying found and the value length, counted up to
// 4095. in flag mode only the final item appears.
// an accepted character passes one input register and one result register on its way to
// its result on the m_ side, with the scan state updated in between.
// throughput is one character per cycle while the receiver does not stall, as the scan
// state takes one update per character between the input register and the result register.
// when the receiver stalls the result register holds its item; the input register still
// drains characters that give no result, and s_tready drops only once a character with a
// result waits behind a full result register.
// reset clears the scan state to whitespace skipping and loads the register defaults
// (option_length 1, flag_mode 0, buffer_size 256). registers sit at byte addresses 0, 8,
// 16 and 24 and must be written by the user only while the block is idle (not enforced).
`timescale 1ns / 1ps

module command_line_option_finder_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// apb configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [cmdopt_pkg::ADDR_W-1:0]        paddr,
	input  logic [cmdopt_pkg::DATA_W-1:0]        pwdata,
	output logic [cmdopt_pkg::DATA_W-1:0]        prdata,
	output logic                                 pready,
	// input items
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [cmdopt_pkg::IN_TDATA_W-1:0]    s_tdata,  // [7:0] char_in
	// result items
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [cmdopt_pkg::OUT_TDATA_W-1:0]   m_tdata,  // [7:0] value_char, [8] found,
	                                                       // [20:9] value_length, [23:21] 0
	output logic                                 m_tuser   // is_final
);

	import cmdopt_pkg::*;

	// configuration registers
	logic [NAME_W-1:0] option_name_q;
	logic [LEN_W-1:0]  option_length_q;
	logic              flag_mode_q;
	logic [BSZ_W-1:0]  buffer_size_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			option_name_q   <= '0;
			option_length_q <= LEN_W'(1);
			flag_mode_q     <= 1'b0;
			buffer_size_q   <= BSZ_W'(256);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_NAME:   option_name_q   <= pwdata[NAME_W-1:0];
				REG_LENGTH: option_length_q <= pwdata[LEN_W-1:0];
				REG_FLAG:   flag_mode_q     <= pwdata[0];
				REG_BUFSZ:  buffer_size_q   <= pwdata[BSZ_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_NAME:   prdata = DATA_W'(option_name_q);
			REG_LENGTH: prdata = DATA_W'(option_length_q);
			REG_FLAG:   prdata = DATA_W'(flag_mode_q);
			REG_BUFSZ:  prdata = DATA_W'(buffer_size_q);
			default:    prdata = '0;
		endcase
	end

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       adv_s1;
	logic       has_res;

	// scan state
	phase_t           phase_q, phase_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;

	// result register
	logic             out_valid_q;
	logic             res_final, res_found;
	logic [7:0]       res_char;
	logic [CNT_W-1:0] res_len;
	logic             final_q, found_q;
	logic [7:0]       vchar_q;
	logic [CNT_W-1:0] vlen_q;

	assign adv_s1   = valid_s1 && (!has_res || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata[7:0];
		end
	end

	// scan step
	logic [POS_W-1:0] len;
	logic [BSZ_W-1:0] bsz;
	logic             ws;
	logic [POS_W-1:0] eff_pos;
	logic [7:0]       name_byte;

	always_comb begin
		len = (option_length_q > LEN_W'(NAME_BYTES)) ? POS_W'(NAME_BYTES)
			: POS_W'(option_length_q);
		bsz = (buffer_size_q > BSZ_W'(BUF_MAX)) ? BSZ_W'(BUF_MAX) : buffer_size_q;
		ws  = is_ws(char_s1);
		eff_pos   = (phase_q == PH_SKIP) ? '0 : pos_q;
		name_byte = option_name_q[8*eff_pos[SEL_W-1:0] +: 8];

		phase_n   = phase_q;
		pos_n     = pos_q;
		cnt_n     = cnt_q;
		has_res   = 1'b0;
		res_final = 1'b0;
		res_found = 1'b0;
		res_char  = '0;
		res_len   = '0;

		if (char_s1 == CH_NUL) begin
			has_res   = 1'b1;
			res_final = 1'b1;
			if (phase_q == PH_VALUE || phase_q == PH_DONE) begin
				res_found = 1'b1;
				res_len   = cnt_q;
			end else if (phase_q == PH_CMP && flag_mode_q && pos_q >= len) begin
				res_found = 1'b1;
			end
			phase_n = PH_SKIP;
			pos_n   = '0;
			cnt_n   = '0;
		end else begin
			unique case (phase_q)
				PH_SKIP, PH_CMP: begin
					if (!(phase_q == PH_SKIP && ws)) begin
						pos_n = eff_pos;
						if (phase_q == PH_SKIP) begin
							cnt_n = '0;
						end
						if (eff_pos < len) begin
							if (char_s1 == name_byte) begin
								pos_n   = eff_pos + POS_W'(1);
								phase_n = PH_CMP;
							end else begin
								phase_n = ws ? PH_SKIP : PH_WORD;
							end
						end else if (!flag_mode_q && char_s1 == CH_EQ) begin
							phase_n = PH_VALUE;
							cnt_n   = '0;
						end else if (flag_mode_q && ws) begin
							phase_n = PH_DONE;
							cnt_n   = '0;
						end else begin
							phase_n = ws ? PH_SKIP : PH_WORD;
						end
					end
				end
				PH_WORD: begin
					if (ws) begin
						phase_n = PH_SKIP;
					end
				end
				PH_VALUE: begin
					if (ws) begin
						phase_n = PH_DONE;
					end else begin
						if (cnt_q < CNT_W'(LENGTH_LIMIT)) begin
							if (({1'b0, cnt_q} + BSZ_W'(1)) < bsz) begin
								has_res  = 1'b1;
								res_char = char_s1;
							end
							cnt_n = cnt_q + CNT_W'(1);
						end
					end
				end
				PH_DONE: ;
				default: phase_n = PH_SKIP;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			pos_q   <= '0;
			cnt_q   <= '0;
		end else if (adv_s1) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			cnt_q   <= cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && has_res) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_res) begin
			final_q <= res_final;
			found_q <= res_found;
			vchar_q <= res_char;
			vlen_q  <= res_len;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = final_q;
	assign m_tdata  = {3'b000, vlen_q, found_q, vchar_q};

	// checks
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(NAME_BYTES))
		else $error("name position beyond name bytes");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(LENGTH_LIMIT))
		else $error("value count above limit");

	a_char_item_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[20:8] == '0))
		else $error("value character item carries found or length");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && char_s1 == CH_NUL) |=> (phase_q == PH_SKIP && cnt_q == '0 && pos_q == '0))
		else $error("scan state not cleared after end of string");

	a_final_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && char_s1 == CH_NUL) |=> (out_valid_q && final_q))
		else $error("end of string gave no final item");

endmodule
